>>> sv/cubic_spline_table_evaluator_assert.svh
// assertion macros for the cubic spline table evaluator
// no dependencies; included by the top level, the rtl file that carries assertions
`ifndef CUBIC_SPLINE_TABLE_EVALUATOR_ASSERT_SVH
`define CUBIC_SPLINE_TABLE_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CSTE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CSTE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CSTE_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define CSTE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> sv/cste_pkg.sv
// shared types, codes, constants and saturation helper for the spline evaluator
// no dependencies
package cste_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 1024;
   localparam int unsigned NUM_SETS_DEF    = 16;
   localparam int unsigned NUM_CH          = 4;
   localparam int unsigned SET_FIELD_W     = 4;
   localparam int unsigned NUM_SET_CODES   = 1 << SET_FIELD_W;
   localparam int unsigned ENTRY_W         = 10;
   localparam int unsigned CSR_IDX_W       = 2;
   localparam int unsigned IDX_LSB         = 40;
   localparam int unsigned FRAC_OFF        = 24;
   localparam int unsigned FRAC_H          = 16;
   localparam int unsigned HORNER_STAGES   = 6;

   localparam logic [31:0] STEP_SIZE_RST     = 32'd16777;
   localparam logic [31:0] INV_STEP_SIZE_RST = 32'd65536000;
   localparam logic [31:0] COULOMB_SCALE_RST = 32'd2842;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

   typedef logic signed [31:0] q16_type;
   // element 0 constant, 1 linear, 2 quadratic, 3 cubic
   typedef q16_type [NUM_CH-1:0] coef_set_type;
   // one memory word: all four channels of one table entry
   typedef coef_set_type [NUM_CH-1:0] entry_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE,
      CSR_INV_STEP_SIZE,
      CSR_COULOMB_SCALE
   } csr_index_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EVAL  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CH_VDW_ENERGY,
      CH_VDW_FORCE,
      CH_COULOMB_ENERGY,
      CH_COULOMB_FORCE
   } channel_type;

   function automatic q16_type sat_q16(input logic signed [63:0] v);
      if (v > Q_MAX) begin
         return 32'sh7fffffff;
      end else if (v < Q_MIN) begin
         return 32'sh80000000;
      end
      return q16_type'(v[31:0]);
   endfunction

endpackage

>>> sv/cste_coef_mem.sv
// coefficient memory: one word per table entry, four channel lanes per word
// single port, lane write, registered read; uses cste_pkg
module cste_coef_mem #(
   parameter int unsigned ADDR_W = 14,
   parameter int unsigned DEPTH  = 16384
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [1:0]            wr_lane,
   input  cste_pkg::coef_set_type wr_data,
   output cste_pkg::entry_type   rd_data
);
   import cste_pkg::*;

   entry_type coef_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[addr][wr_lane] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= coef_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cste_horner_lane.sv
// one channel of the horner pipeline: three multiply stages, three add stages
// uses cste_pkg for the coefficient type and saturation
module cste_horner_lane (
   input  logic                                clock,
   input  logic [cste_pkg::HORNER_STAGES-1:0]  stage_en,
   input  cste_pkg::q16_type                   offset,
   input  cste_pkg::coef_set_type              coef,
   output cste_pkg::q16_type                   result
);
   import cste_pkg::*;

   logic signed [63:0] prod_ff [3];
   q16_type            off_m_ff [3];
   coef_set_type       coef_m_ff [3];
   q16_type            acc_ff [3];
   q16_type            off_a_ff [2];
   coef_set_type       coef_a_ff [2];

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_step
         q16_type      acc_src;
         q16_type      off_src;
         coef_set_type coef_src;

         if (k == 0) begin : g_first
            assign acc_src  = coef[3];
            assign off_src  = offset;
            assign coef_src = coef;
         end else begin : g_next
            assign acc_src  = acc_ff[k-1];
            assign off_src  = off_a_ff[k-1];
            assign coef_src = coef_a_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (stage_en[2*k]) begin
               prod_ff[k]   <= 64'(acc_src) * 64'(off_src);
               off_m_ff[k]  <= off_src;
               coef_m_ff[k] <= coef_src;
            end
            if (stage_en[2*k+1]) begin
               acc_ff[k] <= sat_q16((prod_ff[k] >>> FRAC_OFF)
                                    + 64'($signed(coef_m_ff[k][2-k])));
            end
         end

         if (k < 2) begin : g_carry
            always_ff @(posedge clock) begin
               if (stage_en[2*k+1]) begin
                  off_a_ff[k]  <= off_m_ff[k];
                  coef_a_ff[k] <= coef_m_ff[k];
               end
            end
         end
      end
   endgenerate

   assign result = acc_ff[2];

endmodule

>>> sv/cubic_spline_table_evaluator.sv
// top level of the cubic spline table evaluator: index, address, offset and h stages
// depends on cste_pkg, cste_coef_mem, cste_horner_lane, cubic_spline_table_evaluator_assert.svh
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    func, set, entry, channel, coefs, distance
//   rsp      out        rsp_valid/rsp_ready    four cubics, h term, saturation flag
//   csr      in         csr_write_en           csr_index, csr_data
//
// one item per cycle sustained while rsp_ready holds; an evaluate beat runs through all
// stages to rsp, a write beat leaves the pipe after the memory port in stage 3
// every item uses the single memory port once, in stage 3 (write or read)
// each stage holds only while the stage after it is full and stalled, so bubbles close up
// synchronous reset clears control and loads configuration defaults; table contents stay undefined
`include "cubic_spline_table_evaluator_assert.svh"

module cubic_spline_table_evaluator #(
   parameter int unsigned TABLE_DEPTH = cste_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned NUM_SETS    = cste_pkg::NUM_SETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [cste_pkg::SET_FIELD_W-1:0]  req_table_set,
   input  logic [cste_pkg::ENTRY_W-1:0]      req_entry_index,
   input  logic [1:0]                        req_channel,
   input  logic signed [31:0]                req_coef_const,
   input  logic signed [31:0]                req_coef_lin,
   input  logic signed [31:0]                req_coef_quad,
   input  logic signed [31:0]                req_coef_cubic,
   input  logic [31:0]                       req_distance,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_energy_vdw,
   output logic signed [31:0]                rsp_force_vdw,
   output logic signed [31:0]                rsp_energy_coulomb,
   output logic signed [31:0]                rsp_force_coulomb,
   output logic signed [31:0]                rsp_h_term,
   output logic                              rsp_index_saturated,
   input  logic                              csr_write_en,
   input  logic [cste_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_data
);
   import cste_pkg::*;

   localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
   localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned MEM_DEPTH = NUM_SETS * TABLE_DEPTH;
   localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
   localparam int unsigned KNOT_W    = IDX_W + 1 + 32;
   localparam int unsigned RAW_W     = 64 - IDX_LSB;

   localparam int unsigned ST_PROD  = 1;
   localparam int unsigned ST_ADDR  = 2;
   localparam int unsigned ST_READ  = 3;
   localparam int unsigned ST_OFF   = 4;
   localparam int unsigned ST_H0    = 5;
   localparam int unsigned ST_HMUL  = ST_H0 + HORNER_STAGES;
   localparam int unsigned ST_OUT   = ST_HMUL + 1;

   // configuration
   logic [31:0] step_size_ff;
   logic [31:0] inv_step_size_ff;
   logic [31:0] coulomb_scale_ff;

   // pipeline control
   logic [ST_OUT:ST_PROD] valid_ff;
   logic [ST_OUT:ST_PROD] valid_in;
   logic [ST_OUT:ST_PROD] stage_en;

   // set folding
   logic [SET_W-1:0] set_tbl [NUM_SET_CODES];

   // stage 1
   logic              s1_func_ff;
   logic [SET_W-1:0]  s1_set_ff;
   logic [ENTRY_W-1:0] s1_entry_ff;
   logic [1:0]        s1_chan_ff;
   coef_set_type      s1_coef_ff;
   logic [31:0]       s1_dist_ff;
   logic [63:0]       s1_prod_ff;

   // stage 2
   logic [RAW_W-1:0]  raw_idx;
   logic [IDX_W-1:0]  idx_in;
   logic              sat_in;
   logic [IDX_W-1:0]  row_in;
   logic [ADDR_W-1:0] addr_in;
   logic              s2_func_ff;
   logic [1:0]        s2_chan_ff;
   coef_set_type      s2_coef_ff;
   logic [31:0]       s2_dist_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic              s2_sat_ff;
   logic              s2_wr_ok_ff;

   // stage 3
   logic              mem_wr_en;
   entry_type         mem_rd_data;
   logic [31:0]       s3_dist_ff;
   logic [KNOT_W-1:0] s3_knot_ff;
   logic              s3_sat_ff;

   // stage 4 and the flag line beside the horner lanes
   q16_type           s4_off_ff;
   entry_type         s4_coef_ff;
   logic [ST_HMUL:ST_OFF] sat_line_ff;

   // horner lanes and h stage
   q16_type           lane_result [NUM_CH];
   q16_type           s11_res_ff [NUM_CH];
   logic signed [64:0] s11_hprod_ff;

   // output
   q16_type           out_res_ff [NUM_CH];
   q16_type           out_h_ff;
   logic              out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff     <= STEP_SIZE_RST;
         inv_step_size_ff <= INV_STEP_SIZE_RST;
         coulomb_scale_ff <= COULOMB_SCALE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STEP_SIZE:     step_size_ff     <= csr_data;
            CSR_INV_STEP_SIZE: inv_step_size_ff <= csr_data;
            CSR_COULOMB_SCALE: coulomb_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < NUM_SET_CODES; gi++) begin : g_set_tbl
         assign set_tbl[gi] = SET_W'(gi % NUM_SETS);
      end
   endgenerate

   // a stage loads when it is empty or its content moves on
   always_comb begin
      stage_en[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int s = ST_OUT - 1; s >= ST_PROD; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
      valid_in = {valid_ff[ST_OUT-1:ST_PROD], req_valid};
      // write beats end at the memory port
      valid_in[ST_READ] = valid_ff[ST_ADDR] && (s2_func_ff == FUNC_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = ST_PROD; s <= ST_OUT; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   assign req_ready = stage_en[ST_PROD];

   // stage 1: capture and index product
   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         s1_func_ff  <= req_func;
         s1_set_ff   <= set_tbl[req_table_set];
         s1_entry_ff <= req_entry_index;
         s1_chan_ff  <= req_channel;
         s1_coef_ff  <= {req_coef_cubic, req_coef_quad, req_coef_lin, req_coef_const};
         s1_dist_ff  <= req_distance;
         s1_prod_ff  <= 64'(req_distance) * 64'(inv_step_size_ff);
      end
   end

   // stage 2: clamp index, form memory address
   always_comb begin
      raw_idx = s1_prod_ff[63:IDX_LSB];
      sat_in  = 1'b0;
      if (raw_idx == '0) begin
         idx_in = IDX_W'(1);
      end else if (raw_idx > RAW_W'(TABLE_DEPTH - 1)) begin
         idx_in = IDX_W'(TABLE_DEPTH - 1);
         sat_in = 1'b1;
      end else begin
         idx_in = IDX_W'(raw_idx);
      end
      row_in  = (s1_func_ff == FUNC_WRITE) ? IDX_W'(s1_entry_ff) : idx_in;
      addr_in = ADDR_W'(ADDR_W'(s1_set_ff) * ADDR_W'(TABLE_DEPTH)) + ADDR_W'(row_in);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ADDR]) begin
         s2_func_ff  <= s1_func_ff;
         s2_chan_ff  <= s1_chan_ff;
         s2_coef_ff  <= s1_coef_ff;
         s2_dist_ff  <= s1_dist_ff;
         s2_addr_ff  <= addr_in;
         s2_idx_ff   <= idx_in;
         s2_sat_ff   <= sat_in;
         s2_wr_ok_ff <= (32'(s1_entry_ff) < 32'(TABLE_DEPTH));
      end
   end

   // stage 3: memory access and knot position
   assign mem_wr_en = stage_en[ST_READ] && valid_ff[ST_ADDR]
                      && (s2_func_ff == FUNC_WRITE) && s2_wr_ok_ff;

   cste_coef_mem #(
      .ADDR_W (ADDR_W),
      .DEPTH  (MEM_DEPTH)
   ) u_coef_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (stage_en[ST_READ]),
      .addr    (s2_addr_ff),
      .wr_lane (s2_chan_ff),
      .wr_data (s2_coef_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (stage_en[ST_READ]) begin
         s3_dist_ff <= s2_dist_ff;
         s3_sat_ff  <= s2_sat_ff;
         s3_knot_ff <= KNOT_W'({1'b0, s2_idx_ff} + 1'b1) * KNOT_W'(step_size_ff);
      end
   end

   // stage 4: offset from the knot
   always_ff @(posedge clock) begin
      if (stage_en[ST_OFF]) begin
         s4_off_ff            <= sat_q16(64'(s3_dist_ff) - 64'(s3_knot_ff));
         s4_coef_ff           <= mem_rd_data;
         sat_line_ff[ST_OFF]  <= s3_sat_ff;
      end
      for (int s = ST_H0; s <= ST_HMUL; s++) begin
         if (stage_en[s]) begin
            sat_line_ff[s] <= sat_line_ff[s-1];
         end
      end
   end

   genvar gc;
   generate
      for (gc = 0; gc < NUM_CH; gc++) begin : g_lane
         cste_horner_lane u_lane (
            .clock    (clock),
            .stage_en (stage_en[ST_HMUL-1:ST_H0]),
            .offset   (s4_off_ff),
            .coef     (s4_coef_ff[gc]),
            .result   (lane_result[gc])
         );
      end
   endgenerate

   // register the lane results and coulomb energy times scale
   always_ff @(posedge clock) begin
      if (stage_en[ST_HMUL]) begin
         for (int c = 0; c < NUM_CH; c++) begin
            s11_res_ff[c] <= lane_result[c];
         end
         s11_hprod_ff <= 65'(lane_result[CH_COULOMB_ENERGY])
                         * 65'($signed({1'b0, coulomb_scale_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         for (int c = 0; c < NUM_CH; c++) begin
            out_res_ff[c] <= s11_res_ff[c];
         end
         out_h_ff   <= sat_q16(64'(s11_hprod_ff >>> FRAC_H));
         out_sat_ff <= sat_line_ff[ST_HMUL];
      end
   end

   assign rsp_valid           = valid_ff[ST_OUT];
   assign rsp_energy_vdw      = out_res_ff[CH_VDW_ENERGY];
   assign rsp_force_vdw       = out_res_ff[CH_VDW_FORCE];
   assign rsp_energy_coulomb  = out_res_ff[CH_COULOMB_ENERGY];
   assign rsp_force_coulomb   = out_res_ff[CH_COULOMB_FORCE];
   assign rsp_h_term          = out_h_ff;
   assign rsp_index_saturated = out_sat_ff;

   `CSTE_ASSERT_NEXT(a_accept_loads_s1, clock, reset, req_valid && req_ready, valid_ff[ST_PROD])
   `CSTE_ASSERT_IMPLY(a_empty_s1_ready, clock, reset, !valid_ff[ST_PROD], req_ready)
   `CSTE_ASSERT_IMPLY(a_idx_nonzero, clock, reset, valid_ff[ST_ADDR], s2_idx_ff != '0)
   `CSTE_ASSERT_IMPLY(a_sat_clamps, clock, reset, valid_ff[ST_ADDR] && s2_sat_ff, s2_idx_ff == IDX_W'(TABLE_DEPTH - 1))
   `CSTE_ASSERT_NEXT(a_write_retires, clock, reset, valid_ff[ST_ADDR] && (s2_func_ff == FUNC_WRITE) && stage_en[ST_READ], !valid_ff[ST_READ])

endmodule
